[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define HPT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Default form on clk_i / rst_ni.
`define HPT_ASSERT(lbl, prop, msg) \
  `HPT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/hpt_pkg.sv]
// Package: constants, types and codes of the hashed page table.
package hpt_pkg;

  // Table geometry
  localparam int BUCKETS = 1024;
  localparam int WAYS    = 4;

  // Field widths
  localparam int ADDR_W    = 32;
  localparam int CFG_W     = 11;
  localparam int PROT_W    = 3;
  localparam int FRAME_W   = 12;
  localparam int STATUS_W  = 2;
  localparam int CFG_RESET = 1024;

  // Page divisor 4000 = 32 * 125: shift, then multiply by reciprocal of 125
  localparam int PAGE_DIV    = 4000;
  localparam int PRE_SHIFT   = 5;
  localparam int ODD_DIV     = PAGE_DIV >> PRE_SHIFT;
  localparam int RECIP_SHIFT = 34;
  localparam longint unsigned RECIP_M =
    ((64'd1 << RECIP_SHIFT) + ODD_DIV - 1) / ODD_DIV;
  localparam int QUO_IN_W = ADDR_W - PRE_SHIFT;
  localparam int RECIP_W  = $clog2(RECIP_M + 1);
  localparam int PROD_W   = QUO_IN_W + RECIP_W;
  localparam int PAGE_W   = PROD_W - RECIP_SHIFT;

  // Bucket select and modulo unit
  localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NMOD_W    = BKT_W + 1;
  localparam int MOD_BITS  = 7;
  localparam int MOD_CYC   = (PAGE_W + MOD_BITS - 1) / MOD_BITS;
  localparam int MOD_PAD_W = MOD_CYC * MOD_BITS;
  localparam int MCNT_W    = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

  // Slots and entry store
  localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_W      = $clog2(WAYS + 1);
  localparam int ENTRY_DEPTH = BUCKETS * WAYS;
  localparam int ENTRY_AW    = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_HIT      = 2'd2,
    ST_MISS     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_MOD,
    S_FILL_RD,
    S_FILL_CHK,
    S_RD,
    S_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [PROT_W-1:0]  prot;
    logic               modified;
    logic               referenced;
    logic               cache;
  } map_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    map_t              map;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    mul_en;
    logic    mod_en;
    logic    clr_wr;
    logic    ins_wr;
    logic    fill_cap;
    logic    way_clr;
    logic    way_inc;
    logic    res_set;
    status_e res_status;
    logic    res_hit;
    logic    out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic lookup;
    logic mod_last;
    logic clr_last;
    logic fill_full;
    logic fill_zero;
    logic hit;
    logic way_last;
  } sts_t;

endpackage

[hw/rtl/hpt_if.sv]
// Channel interfaces: request (operation) and response (result) with valid/ready.
interface hpt_req_if;
  import hpt_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [ADDR_W-1:0]  virtual_address;
  logic               cache_flag;
  logic               referenced_flag;
  logic               modified_flag;
  logic [PROT_W-1:0]  protection_bits;
  logic [FRAME_W-1:0] frame_number;

  modport source (
    output valid, operation, virtual_address, cache_flag, referenced_flag,
           modified_flag, protection_bits, frame_number,
    input  ready
  );

  modport sink (
    input  valid, operation, virtual_address, cache_flag, referenced_flag,
           modified_flag, protection_bits, frame_number,
    output ready
  );
endinterface

interface hpt_rsp_if;
  import hpt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                hit_cache_flag;
  logic                hit_referenced_flag;
  logic                hit_modified_flag;
  logic [PROT_W-1:0]   hit_protection;
  logic [FRAME_W-1:0]  hit_frame;

  modport source (
    output valid, status, hit_cache_flag, hit_referenced_flag, hit_modified_flag,
           hit_protection, hit_frame,
    input  ready
  );

  modport sink (
    input  valid, status, hit_cache_flag, hit_referenced_flag, hit_modified_flag,
           hit_protection, hit_frame,
    output ready
  );
endinterface

[hw/rtl/hpt_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module hpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/hpt_ctrl.sv]
// Controller: sequences clearing, hashing, fill read, insert and slot scan.
module hpt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  hpt_pkg::sts_t sts_i,
  output hpt_pkg::cmd_t cmd_o
);
  import hpt_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_MOD;
      end
      S_MOD: begin
        cmd_o.mod_en = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_FILL_RD;
        end
      end
      S_FILL_RD: begin
        state_d = S_FILL_CHK;
      end
      S_FILL_CHK: begin
        cmd_o.fill_cap = 1'b1;
        cmd_o.way_clr  = 1'b1;
        if (!sts_i.lookup) begin
          cmd_o.res_set = 1'b1;
          if (sts_i.fill_full) begin
            cmd_o.res_status = ST_DROPPED;
          end else begin
            cmd_o.ins_wr     = 1'b1;
            cmd_o.res_status = ST_INSERTED;
          end
          state_d = S_DONE;
        end else if (sts_i.fill_zero) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_MISS;
          state_d          = S_DONE;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (sts_i.hit) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_HIT;
          cmd_o.res_hit    = 1'b1;
          state_d          = S_DONE;
        end else if (sts_i.way_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_MISS;
          state_d          = S_DONE;
        end else begin
          cmd_o.way_inc = 1'b1;
          state_d       = S_RD;
        end
      end
      S_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register holds until the transfer completes
  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/hpt_datapath.sv]
// Datapath: config register, page divide, bucket modulo, fill and entry memories.
module hpt_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hpt_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  hpt_pkg::cmd_t               cmd_i,
  output hpt_pkg::sts_t               sts_o,
  input  logic                        op_i,
  input  logic [hpt_pkg::ADDR_W-1:0]  addr_i,
  input  logic                        cache_i,
  input  logic                        referenced_i,
  input  logic                        modified_i,
  input  logic [hpt_pkg::PROT_W-1:0]  prot_i,
  input  logic [hpt_pkg::FRAME_W-1:0] frame_i,
  output hpt_pkg::status_e            status_o,
  output hpt_pkg::map_t               map_o
);
  import hpt_pkg::*;

  // One modulo chunk: MOD_BITS restoring steps, MSB first
  function automatic logic [BKT_W-1:0] mod_chunk(
    input logic [BKT_W-1:0]    r,
    input logic [MOD_BITS-1:0] bits,
    input logic [NMOD_W-1:0]   n
  );
    logic [NMOD_W-1:0] acc;
    logic [NMOD_W-1:0] t;
    acc = NMOD_W'(r);
    for (int i = MOD_BITS - 1; i >= 0; i--) begin
      t = {acc[NMOD_W-2:0], bits[i]};
      if (t >= n) begin
        t = t - n;
      end
      acc = t;
    end
    return acc[BKT_W-1:0];
  endfunction

  function automatic logic [ENTRY_AW-1:0] ent_addr(
    input logic [BKT_W-1:0] bkt,
    input logic [WAY_W-1:0] way
  );
    return ENTRY_AW'(bkt) * ENTRY_AW'(WAYS) + ENTRY_AW'(way);
  endfunction

  logic [CFG_W-1:0]     buckets_q;
  logic                 op_q;
  logic [ADDR_W-1:0]    addr_q;
  map_t                 map_q;
  logic [MOD_PAD_W-1:0] page_q;
  logic [BKT_W-1:0]     rem_q;
  logic [MCNT_W-1:0]    mcnt_q;
  logic [WAY_W-1:0]     way_q;
  logic [FILL_W-1:0]    fill_q;
  logic [BKT_W-1:0]     clr_q;
  status_e              pend_status_q, out_status_q;
  map_t                 pend_map_q, out_map_q;

  logic [NMOD_W-1:0]    n_mod;
  logic [PROD_W-1:0]    prod;
  logic                 fill_we;
  logic [BKT_W-1:0]     fill_waddr;
  logic [FILL_W-1:0]    fill_wdata;
  logic [FILL_W-1:0]    fill_rd;
  logic [ENTRY_W-1:0]   ent_rd_raw;
  entry_t               ent_rd;
  entry_t               ent_wr;

  // Bucket count register, taken whenever written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buckets_q <= CFG_W'(CFG_RESET);
    end else if (cfg_we_i) begin
      buckets_q <= cfg_wdata_i;
    end
  end

  // Effective modulus: zero acts as one, above the table size saturates
  always_comb begin
    if (buckets_q == '0) begin
      n_mod = NMOD_W'(1);
    end else if (int'(buckets_q) > BUCKETS) begin
      n_mod = NMOD_W'(BUCKETS);
    end else begin
      n_mod = NMOD_W'(buckets_q);
    end
  end

  // Page number by reciprocal multiply
  assign prod = PROD_W'(addr_q[ADDR_W-1:PRE_SHIFT]) * PROD_W'(RECIP_M);

  // Item capture, divide and modulo sequencing
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q                 <= op_i;
      addr_q               <= addr_i;
      map_q.cache          <= cache_i;
      map_q.referenced     <= referenced_i;
      map_q.modified       <= modified_i;
      map_q.prot           <= prot_i;
      map_q.frame          <= frame_i;
      rem_q                <= '0;
    end
    if (cmd_i.mul_en) begin
      page_q <= MOD_PAD_W'(prod[PROD_W-1:RECIP_SHIFT]);
    end
    if (cmd_i.mod_en) begin
      rem_q  <= mod_chunk(rem_q, page_q[MOD_PAD_W-1 -: MOD_BITS], n_mod);
      page_q <= page_q << MOD_BITS;
    end
    if (cmd_i.fill_cap) begin
      fill_q <= fill_rd;
    end
  end

  // Counters: modulo chunk, slot scan and clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
      way_q  <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.capture) begin
        mcnt_q <= '0;
      end else if (cmd_i.mod_en) begin
        mcnt_q <= mcnt_q + MCNT_W'(1);
      end
      if (cmd_i.way_clr) begin
        way_q <= '0;
      end else if (cmd_i.way_inc) begin
        way_q <= way_q + WAY_W'(1);
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + BKT_W'(1);
      end
    end
  end

  // Fill count memory: cleared by the sweep, bumped on insert
  assign fill_we    = cmd_i.clr_wr | cmd_i.ins_wr;
  assign fill_waddr = cmd_i.clr_wr ? clr_q : rem_q;
  assign fill_wdata = cmd_i.clr_wr ? '0 : fill_rd + FILL_W'(1);

  hpt_ram #(
    .WIDTH (FILL_W),
    .DEPTH (BUCKETS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .raddr_i (rem_q),
    .rdata_o (fill_rd)
  );

  // Entry memory: slot = bucket * WAYS + way
  assign ent_wr.addr = addr_q;
  assign ent_wr.map  = map_q;

  hpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRY_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins_wr),
    .waddr_i (ent_addr(rem_q, fill_rd[WAY_W-1:0])),
    .wdata_i (ent_wr),
    .raddr_i (ent_addr(rem_q, way_q)),
    .rdata_o (ent_rd_raw)
  );

  assign ent_rd = entry_t'(ent_rd_raw);

  // Status to the controller
  assign sts_o.lookup    = op_q;
  assign sts_o.mod_last  = (int'(mcnt_q) == MOD_CYC - 1);
  assign sts_o.clr_last  = (int'(clr_q) == BUCKETS - 1);
  assign sts_o.fill_full = (int'(fill_rd) >= WAYS);
  assign sts_o.fill_zero = (fill_rd == '0);
  assign sts_o.hit       = (ent_rd.addr == addr_q);
  assign sts_o.way_last  = ((int'(way_q) + 1) >= int'(fill_q));

  // Pending result, then output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      pend_status_q <= cmd_i.res_status;
      pend_map_q    <= cmd_i.res_hit ? ent_rd.map : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= pend_status_q;
      out_map_q    <= pend_map_q;
    end
  end

  assign status_o = out_status_q;
  assign map_o    = out_map_q;

endmodule

[hw/rtl/hashed_page_table.sv]
// Top level of the hashed page table: controller plus datapath.
// Sequence: an insert runs the divide, the bucket modulo, the fill read and the fill check, then
//   loads its result; a lookup adds a read and compare per slot read (1..WAYS), none on an empty bucket.
// Flow: one item at a time; the next is taken at the earliest in the cycle after the result is loaded,
//   and the divide and the bucket modulo set the floor.
// Reset: a clearing pass over all 1024 buckets zeroes the fill counts; no item is taken meanwhile.
module hashed_page_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hpt_pkg::CFG_W-1:0] cfg_wdata_i,
  hpt_req_if.sink                   req_i,
  hpt_rsp_if.source                 rsp_o
);
  import hpt_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  logic    in_ready;
  logic    out_valid;
  status_e out_status;
  map_t    out_map;

  // Sequencer
  hpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic
  hpt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (req_i.operation),
    .addr_i       (req_i.virtual_address),
    .cache_i      (req_i.cache_flag),
    .referenced_i (req_i.referenced_flag),
    .modified_i   (req_i.modified_flag),
    .prot_i       (req_i.protection_bits),
    .frame_i      (req_i.frame_number),
    .status_o     (out_status),
    .map_o        (out_map)
  );

  // Channel hookup
  assign req_i.ready               = in_ready;
  assign rsp_o.valid               = out_valid;
  assign rsp_o.status              = out_status;
  assign rsp_o.hit_cache_flag      = out_map.cache;
  assign rsp_o.hit_referenced_flag = out_map.referenced;
  assign rsp_o.hit_modified_flag   = out_map.modified;
  assign rsp_o.hit_protection      = out_map.prot;
  assign rsp_o.hit_frame           = out_map.frame;

endmodule

[hw/rtl/hpt_checker.sv]
// Port-level checker for the hashed page table, bound to the top level.
`include "assert_macros.svh"

module hpt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [hpt_pkg::STATUS_W-1:0] rsp_status_i,
  input logic                        rsp_cache_i,
  input logic                        rsp_referenced_i,
  input logic                        rsp_modified_i,
  input logic [hpt_pkg::PROT_W-1:0]  rsp_prot_i,
  input logic [hpt_pkg::FRAME_W-1:0] rsp_frame_i
);
  import hpt_pkg::*;

  // A stalled result holds
  `HPT_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_frame_i), "result changed while stalled")

  // Only a hit carries mapping fields
  `HPT_ASSERT(a_nohit_zero, rsp_valid_i && (rsp_status_i != ST_HIT) |-> (rsp_frame_i == '0) && (rsp_prot_i == '0) && !rsp_cache_i && !rsp_referenced_i && !rsp_modified_i, "non-hit result with mapping fields")

  // One item in flight: no transfer in right after one
  `HPT_ASSERT(a_one_item, req_valid_i && req_ready_i |=> !req_ready_i, "ready right after a transfer in")

  // A new result is loaded only while no item is taken
  `HPT_ASSERT(a_rsp_from_busy, $rose(rsp_valid_i) |-> !$past(req_ready_i), "result appeared while idle")

endmodule

bind hashed_page_table hpt_checker u_hpt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_cache_i      (rsp_o.hit_cache_flag),
  .rsp_referenced_i (rsp_o.hit_referenced_flag),
  .rsp_modified_i   (rsp_o.hit_modified_flag),
  .rsp_prot_i       (rsp_o.hit_protection),
  .rsp_frame_i      (rsp_o.hit_frame)
);

[tb/tb_top.sv]
// Testbench for the hashed page table: queued stimulus, handshake driver, result checker.
`timescale 1ns / 100ps

module tb_top;
  import hpt_pkg::*;

  localparam logic        OP_INSERT   = 1'b0;
  localparam logic        OP_LOOKUP   = 1'b1;
  localparam int unsigned PAGE_SIZE   = 4000;
  localparam int          MAP_W       = $bits(map_t);
  localparam int          DRAIN_WAIT  = 24;
  localparam int          HOLD_CYCLES = 400;
  localparam int          MAX_CYCLES  = 600000;

  typedef enum int {IDLE_OFF, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] vaddr;
    map_t              map;
  } pte_req_t;

  typedef struct packed {
    status_e status;
    map_t    map;
  } pte_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              hold_start = 1'b0;
  int unsigned       hold_cnt;

  hpt_req_if req_if ();
  hpt_rsp_if rsp_if ();

  hashed_page_table DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #10 clk = ~clk;

  // Mirror of the table
  logic [CFG_W-1:0]  bucket_cfg = CFG_W'(CFG_RESET);
  logic [ADDR_W-1:0] slot_vaddr [BUCKETS][WAYS];
  map_t              slot_map   [BUCKETS][WAYS];
  int unsigned       fill_cnt   [BUCKETS];

  pte_req_t          pte_req_q[$];
  pte_result_t       pte_result_q[$];
  logic [ADDR_W-1:0] addr_pool[$];
  pte_req_t          in_flight;
  idle_mode_e        idle_mode = IDLE_OFF;
  int unsigned       queued_cnt = 0;
  int unsigned       accepted_cnt = 0;
  int unsigned       err_cnt = 0;
  int unsigned       cycle_cnt = 0;

  // Bucket count as the hardware applies it: 0 acts as 1, clamp at BUCKETS
  function automatic int unsigned eff_buckets();
    int unsigned n;
    n = bucket_cfg;
    if (n == 0) n = 1;
    if (n > BUCKETS) n = BUCKETS;
    return n;
  endfunction

  // Insert appends to the bucket; lookup returns the earliest matching slot
  function automatic pte_result_t walk_page_table(input pte_req_t rq);
    int unsigned bkt;
    pte_result_t res;
    bkt = (rq.vaddr / PAGE_SIZE) % eff_buckets();
    res = '0;
    if (rq.op == OP_INSERT) begin
      if (fill_cnt[bkt] >= WAYS) begin
        res.status = ST_DROPPED;
      end else begin
        slot_vaddr[bkt][fill_cnt[bkt]] = rq.vaddr;
        slot_map[bkt][fill_cnt[bkt]]   = rq.map;
        fill_cnt[bkt]++;
        res.status = ST_INSERTED;
      end
    end else begin
      res.status = ST_MISS;
      // walk backwards so the earliest match is the one that stays
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (w < fill_cnt[bkt] && slot_vaddr[bkt][w] == rq.vaddr) begin
          res.status = ST_HIT;
          res.map    = slot_map[bkt][w];
        end
      end
    end
    return res;
  endfunction

  function automatic bit draw_gap(input bit active);
    int unsigned pct;
    pct = (idle_mode == IDLE_BOTH) ? 26 : 57;
    return active && ($urandom_range(99) < pct);
  endfunction

  // Random request: fresh address, reused address, or a neighbor in the same bucket
  function automatic pte_req_t random_pte_req();
    pte_req_t          rq;
    int unsigned       pick;
    longint unsigned   page;
    logic [ADDR_W-1:0] seed_addr;
    rq.op  = ($urandom_range(99) < 50) ? OP_INSERT : OP_LOOKUP;
    rq.map = MAP_W'($urandom);
    pick   = $urandom_range(99);
    if (addr_pool.size() == 0 || pick < 30) begin
      rq.vaddr = $urandom;
    end else begin
      seed_addr = addr_pool[$urandom_range(addr_pool.size() - 1)];
      if (pick < 70) begin
        rq.vaddr = seed_addr;
      end else begin
        page     = seed_addr / PAGE_SIZE + $urandom_range(1, 5) * eff_buckets();
        rq.vaddr = ADDR_W'(page * PAGE_SIZE + $urandom_range(PAGE_SIZE - 1));
      end
    end
    return rq;
  endfunction

  task automatic queue_pte(input logic op, input logic [ADDR_W-1:0] va, input map_t m);
    pte_req_t rq;
    rq.op    = op;
    rq.vaddr = va;
    rq.map   = m;
    pte_req_q.push_back(rq);
    queued_cnt++;
    if (op == OP_INSERT) addr_pool.push_back(va);
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || pte_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_buckets(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    bucket_cfg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input logic [CFG_W-1:0] value, input idle_mode_e mode,
                            input int n_items, input bit with_hold);
    pte_req_t rq;
    wait_drained();
    write_buckets(value);
    idle_mode = mode;
    for (int i = 0; i < n_items; i++) begin
      rq = random_pte_req();
      queue_pte(rq.op, rq.vaddr, rq.map);
    end
    if (with_hold) begin
      @(posedge clk);
      hold_start <= 1'b1;
      @(posedge clk);
      hold_start <= 1'b0;
    end
    wait_drained();
  endtask

  // Request driver: hold valid until the transfer, then take the next item
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        pte_result_q.push_back(walk_page_table(in_flight));
        accepted_cnt++;
      end
      if (pte_req_q.size() != 0 &&
          !draw_gap(idle_mode inside {IDLE_SENDER, IDLE_BOTH})) begin
        in_flight = pte_req_q.pop_front();
        req_if.valid           <= 1'b1;
        req_if.operation       <= in_flight.op;
        req_if.virtual_address <= in_flight.vaddr;
        req_if.cache_flag      <= in_flight.map.cache;
        req_if.referenced_flag <= in_flight.map.referenced;
        req_if.modified_flag   <= in_flight.map.modified;
        req_if.protection_bits <= in_flight.map.prot;
        req_if.frame_number    <= in_flight.map.frame;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_start) begin
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Result monitor: compare each transfer with the oldest prediction
  always @(posedge clk or negedge rst_n) begin : result_check
    pte_result_t got;
    pte_result_t want;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.status = status_e'(rsp_if.status);
        got.map    = {rsp_if.hit_frame, rsp_if.hit_protection, rsp_if.hit_modified_flag,
                      rsp_if.hit_referenced_flag, rsp_if.hit_cache_flag};
        if (pte_result_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result status=%0d frame=%0h", $time,
                   rsp_if.status, rsp_if.hit_frame);
        end else begin
          want = pte_result_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            $display("%0t: expected %s c=%0b r=%0b m=%0b prot=%0d frame=%0h, actual %0d c=%0b r=%0b m=%0b prot=%0d frame=%0h",
                     $time, want.status.name(), want.map.cache, want.map.referenced,
                     want.map.modified, want.map.prot, want.map.frame,
                     rsp_if.status, got.map.cache, got.map.referenced,
                     got.map.modified, got.map.prot, got.map.frame);
          end
        end
      end
      rsp_if.ready <= (hold_cnt == 0) &&
                      !draw_gap(idle_mode inside {IDLE_RECEIVER, IDLE_BOTH});
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    req_if.valid           = 1'b0;
    req_if.operation       = OP_INSERT;
    req_if.virtual_address = '0;
    req_if.cache_flag      = 1'b0;
    req_if.referenced_flag = 1'b0;
    req_if.modified_flag   = 1'b0;
    req_if.protection_bits = '0;
    req_if.frame_number    = '0;
    rsp_if.ready           = 1'b0;
    for (int b = 0; b < BUCKETS; b++) fill_cnt[b] = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset bucket count: empty lookup, extremes, duplicates, full bucket 0
    queue_pte(OP_LOOKUP, 32'h0, '0);
    queue_pte(OP_INSERT, 32'h0, '1);
    queue_pte(OP_LOOKUP, 32'h0, '0);
    queue_pte(OP_INSERT, 32'hFFFF_FFFF, '0);
    queue_pte(OP_LOOKUP, 32'hFFFF_FFFF, '1);
    queue_pte(OP_INSERT, 32'h0, 18'h2A5A5);
    queue_pte(OP_LOOKUP, 32'h0, '0);
    queue_pte(OP_INSERT, 32'd4096000, 18'h15A5A);
    queue_pte(OP_INSERT, 32'd8192000, 18'h3C3C3);
    queue_pte(OP_INSERT, 32'd12288000, '1);
    queue_pte(OP_LOOKUP, 32'd12288000, '0);
    queue_pte(OP_LOOKUP, 32'd8192000, '0);
    queue_pte(OP_LOOKUP, 32'd3999, '0);
    wait_drained();

    // Zero count acts as one bucket; old entries stay where they were put
    write_buckets('0);
    queue_pte(OP_INSERT, 32'd123456789, '1);
    queue_pte(OP_LOOKUP, 32'hFFFF_FFFF, '0);
    queue_pte(OP_LOOKUP, 32'd4096000, '0);
    wait_drained();

    // Oversized count clamps to the table size
    write_buckets('1);
    queue_pte(OP_LOOKUP, 32'hFFFF_FFFF, '0);
    queue_pte(OP_INSERT, 32'hFFFF_FFFF, 18'h1F0F0);
    queue_pte(OP_LOOKUP, 32'h8000_0000, '0);
    wait_drained();

    run_random(CFG_W'(1024), IDLE_OFF, 300, 1'b1);
    run_random(CFG_W'(3), IDLE_SENDER, 250, 1'b0);
    run_random(CFG_W'(1025), IDLE_RECEIVER, 300, 1'b0);
    run_random(CFG_W'(700), IDLE_BOTH, 300, 1'b0);
    run_random(CFG_W'($urandom_range(2, 2047)), IDLE_BOTH, 300, 1'b0);
    run_random(CFG_W'(1), IDLE_OFF, 120, 1'b0);
    run_random('1, IDLE_SENDER, 280, 1'b0);
    run_random('0, IDLE_RECEIVER, 150, 1'b0);

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/hpt_pkg.sv
hw/rtl/hpt_if.sv
hw/rtl/hpt_ram.sv
hw/rtl/hpt_ctrl.sv
hw/rtl/hpt_datapath.sv
hw/rtl/hashed_page_table.sv
hw/rtl/hpt_checker.sv
tb/tb_top.sv
